@@ hw/rtl/bws_pkg.sv @@
// Shared types, constants and register codes for the box window sum block.
package bws_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int SUM_BITS       = 26;
    localparam int RADIUS_BITS    = 4;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int RADIUS_MAX     = 15;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int DEF_MAX_RADIUS = 15;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;
    localparam int OUT_FIFO_DEPTH = 3;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RST = RADIUS_BITS'(1);
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = WIDTH_BITS'(1024);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = HEIGHT_BITS'(1024);

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pixel_value;
        logic                          pad;
    } t_sample;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] box_sum;
        logic                       last_of_frame;
    } t_result;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        logic [WIDTH_BITS-1:0]  image_width;
        logic [HEIGHT_BITS-1:0] image_height;
    } t_cfg;

endpackage

@@ hw/rtl/bws_out_fifo.sv @@
// Small result queue between the summing pipeline and the output channel.
module bws_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bws_pkg::t_result  i_data,
    input  logic              i_ready,
    output logic              o_valid,
    output bws_pkg::t_result  o_data,
    output logic [$clog2(bws_pkg::OUT_FIFO_DEPTH+1)-1:0] o_count
);

    localparam int DEPTH = bws_pkg::OUT_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bws_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !pop |-> r_count < CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("result queue count lost a push");

endmodule

@@ hw/rtl/bws_core.sv @@
// Raster walker, line and column-sum memories, and horizontal running sum.
module bws_core #(
    parameter int MAX_RADIUS = bws_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = bws_pkg::DEF_MAX_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bws_pkg::t_cfg     i_cfg,
    input  logic              i_restart,
    input  logic              i_accept,
    input  bws_pkg::t_sample  i_sample,
    output logic              o_busy,
    output logic              o_push,
    output bws_pkg::t_result  o_result
);

    localparam int SB       = bws_pkg::SAMPLE_BITS;
    localparam int SUM_W    = bws_pkg::SUM_BITS;
    localparam int RB       = bws_pkg::RADIUS_BITS;
    localparam int MAX_R    = (MAX_RADIUS > bws_pkg::RADIUS_MAX) ?
                              bws_pkg::RADIUS_MAX : MAX_RADIUS;
    localparam int N_SLOTS  = 2 * MAX_R + 1;
    localparam int NW       = $clog2(N_SLOTS + 1);
    localparam int HW       = $clog2(N_SLOTS);
    localparam int COL_W    = $clog2(MAX_WIDTH + MAX_R + 1);
    localparam int ROW_W    = $clog2(bws_pkg::HEIGHT_LIMIT + MAX_R + 1);
    localparam int LS_DEPTH = N_SLOTS * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int CA_W     = $clog2(MAX_WIDTH);
    localparam int CS_W     = SB + $clog2(N_SLOTS);

    // effective (clamped) configuration
    logic [RB-1:0]    r_eff;
    logic [NW-1:0]    n_eff;
    logic [COL_W-1:0] w_eff, col_lim;
    logic [ROW_W-1:0] h_eff, row_lim;

    always_comb begin
        r_eff = (32'(i_cfg.radius) > 32'(MAX_R)) ? RB'(MAX_R) : i_cfg.radius;
        n_eff = NW'({r_eff, 1'b1});
        if (i_cfg.image_width == '0) begin
            w_eff = COL_W'(1);
        end else if (32'(i_cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (32'(i_cfg.image_height) > 32'(bws_pkg::HEIGHT_LIMIT)) begin
            h_eff = ROW_W'(bws_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = ROW_W'(i_cfg.image_height);
        end
        col_lim = w_eff + COL_W'(r_eff);
        row_lim = h_eff + ROW_W'(r_eff);
    end

    // raster position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [HW-1:0]    r_hptr, n_hptr;
    logic [HW-1:0]    r_vslot, n_vslot;
    logic [LS_AW-1:0] r_lbase, n_lbase;
    logic             col_last, row_last;

    assign col_last = (r_col == col_lim - 1'b1);
    assign row_last = (r_row == row_lim - 1'b1);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_hptr  = r_hptr;
        n_vslot = r_vslot;
        n_lbase = r_lbase;
        if (i_restart) begin
            n_col   = '0;
            n_row   = '0;
            n_hptr  = '0;
            n_vslot = '0;
            n_lbase = '0;
        end else if (i_accept) begin
            if (col_last) begin
                n_col  = '0;
                n_hptr = '0;
                n_row  = row_last ? '0 : r_row + 1'b1;
                if (row_last || (NW'(r_vslot) == n_eff - 1'b1)) begin
                    n_vslot = '0;
                    n_lbase = '0;
                end else begin
                    n_vslot = r_vslot + 1'b1;
                    n_lbase = r_lbase + LS_AW'(MAX_WIDTH);
                end
            end else begin
                n_col  = r_col + 1'b1;
                n_hptr = (NW'(r_hptr) == n_eff - 1'b1) ? '0 : r_hptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_hptr  <= '0;
            r_vslot <= '0;
            r_lbase <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_hptr  <= n_hptr;
            r_vslot <= n_vslot;
            r_lbase <= n_lbase;
        end
    end

    // front stage decode
    logic                 in_img, col_wr;
    logic signed [SB-1:0] v_in;
    logic [LS_AW-1:0]     ls_addr;
    logic [CA_W-1:0]      cs_addr;

    assign in_img  = (r_row < h_eff) && (r_col < w_eff);
    assign col_wr  = (r_col < w_eff);
    assign v_in    = (!i_sample.pad && in_img) ? i_sample.pixel_value : '0;
    assign ls_addr = r_lbase + LS_AW'(r_col);
    assign cs_addr = CA_W'(r_col);

    // back stage: read-modify-write
    logic                   r_s1_valid;
    logic signed [SB-1:0]   r_s1_v;
    logic                   r_s1_col_wr, r_s1_use_old, r_s1_use_base;
    logic                   r_s1_j0, r_s1_jgn, r_s1_emit, r_s1_last;
    logic [HW-1:0]          r_s1_hslot;
    logic [LS_AW-1:0]       r_s1_ls_addr;
    logic [CA_W-1:0]        r_s1_cs_addr;
    logic                   r_fwd_cs, r_fwd_ls;
    logic signed [CS_W-1:0] r_fwd_cs_val;
    logic signed [SB-1:0]   r_fwd_ls_val;
    logic signed [CS_W-1:0] r_cs_q;
    logic signed [SB-1:0]   r_ls_q;
    logic signed [SUM_W-1:0] r_run;
    logic signed [CS_W-1:0] r_row_win [N_SLOTS];

    logic signed [CS_W-1:0]  cs_mem [MAX_WIDTH];
    logic signed [SB-1:0]    ls_mem [LS_DEPTH];

    logic                    s1_wr;
    logic signed [CS_W-1:0]  base, old, s1_csum, leaving;
    logic signed [SUM_W-1:0] run_nx;

    assign s1_wr = r_s1_valid && r_s1_col_wr;

    always_comb begin
        base    = '0;
        old     = '0;
        s1_csum = '0;
        leaving = '0;
        if (r_s1_use_base) begin
            base = r_fwd_cs ? r_fwd_cs_val : r_cs_q;
        end
        if (r_s1_use_old) begin
            old = CS_W'(r_fwd_ls ? r_fwd_ls_val : r_ls_q);
        end
        if (r_s1_col_wr) begin
            s1_csum = base + CS_W'(r_s1_v) - old;
        end
        if (r_s1_jgn) begin
            leaving = r_row_win[r_s1_hslot];
        end
        run_nx = (r_s1_j0 ? '0 : r_run) + SUM_W'(s1_csum) - SUM_W'(leaving);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_v        <= v_in;
            r_s1_col_wr   <= col_wr;
            r_s1_use_old  <= (r_row >= ROW_W'(n_eff));
            r_s1_use_base <= (r_row != '0);
            r_s1_j0       <= (r_col == '0);
            r_s1_jgn      <= (r_col >= COL_W'(n_eff));
            r_s1_emit     <= (r_row >= ROW_W'(r_eff)) && (r_col >= COL_W'(r_eff));
            r_s1_last     <= row_last && col_last;
            r_s1_hslot    <= r_hptr;
            r_s1_ls_addr  <= ls_addr;
            r_s1_cs_addr  <= cs_addr;
            // the item ahead writes the same entry at this edge: read returns stale data
            r_fwd_cs      <= s1_wr && (r_s1_cs_addr == cs_addr);
            r_fwd_ls      <= s1_wr && (r_s1_ls_addr == ls_addr);
            r_fwd_cs_val  <= s1_csum;
            r_fwd_ls_val  <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            cs_mem[r_s1_cs_addr] <= s1_csum;
        end
        if (i_accept && col_wr) begin
            r_cs_q <= cs_mem[cs_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            ls_mem[r_s1_ls_addr] <= r_s1_v;
        end
        if (i_accept && col_wr) begin
            r_ls_q <= ls_mem[ls_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_run                 <= run_nx;
            r_row_win[r_s1_hslot] <= s1_csum;
        end
    end

    assign o_busy                 = r_s1_valid;
    assign o_push                 = r_s1_valid && r_s1_emit;
    assign o_result.box_sum       = run_nx;
    assign o_result.last_of_frame = r_s1_last;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < col_lim)
        else $error("column position beyond extended row");

    a_hptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_hptr) < n_eff && NW'(r_vslot) < n_eff)
        else $error("window slot pointer beyond window size");

    a_hptr_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col == '0 |-> r_hptr == '0)
        else $error("horizontal slot not aligned to row start");

    a_vslot_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row == '0 |-> r_vslot == '0 && r_lbase == '0)
        else $error("line store row base not aligned to frame start");

endmodule

@@ hw/rtl/box_window_sum_2d.sv @@
// An accepted sample is registered in the back stage, then its result enters the queue.
// Throughput: one item per cycle while o_in_ready is high, set by the read-modify-write of the
//   column-sum and line memories (back-to-back hits on one entry are forwarded).
// o_in_ready drops once the three-entry result queue plus the back-stage item fill it.
// Reset restores the default registers and restarts the frame; memories are not
//   cleared (no clearing pass). Any register write also restarts the frame.
module box_window_sum_2d #(
    parameter int MAX_RADIUS = bws_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = bws_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bws_pkg::t_sample                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bws_pkg::t_result                   o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bws_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [bws_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bws_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    localparam int CNT_W = $clog2(bws_pkg::OUT_FIFO_DEPTH + 1);
    localparam int DW    = bws_pkg::APB_DATA_BITS;

    bws_pkg::t_cfg     r_cfg;
    bws_pkg::t_reg_idx reg_idx;
    bws_pkg::t_result  core_result;
    logic              cfg_wr, accept, busy, push;
    logic [CNT_W-1:0]  fifo_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = bws_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius       <= bws_pkg::RADIUS_RST;
            r_cfg.image_width  <= bws_pkg::WIDTH_RST;
            r_cfg.image_height <= bws_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                bws_pkg::REG_RADIUS: begin
                    r_cfg.radius <= pwdata[bws_pkg::RADIUS_BITS-1:0];
                end
                bws_pkg::REG_WIDTH: begin
                    r_cfg.image_width <= pwdata[bws_pkg::WIDTH_BITS-1:0];
                end
                bws_pkg::REG_HEIGHT: begin
                    r_cfg.image_height <= pwdata[bws_pkg::HEIGHT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bws_pkg::REG_RADIUS: prdata = DW'(r_cfg.radius);
            bws_pkg::REG_WIDTH:  prdata = DW'(r_cfg.image_width);
            bws_pkg::REG_HEIGHT: prdata = DW'(r_cfg.image_height);
            default:             prdata = '0;
        endcase
    end

    // room for the queued results plus the item in the back stage
    assign o_in_ready = ((CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(busy))
                        < (CNT_W + 1)'(bws_pkg::OUT_FIFO_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    bws_core #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (cfg_wr),
        .i_accept  (accept),
        .i_sample  (i_in_data),
        .o_busy    (busy),
        .o_push    (push),
        .o_result  (core_result)
    );

    bws_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (core_result),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_count (fifo_count)
    );

endmodule
